@@ rtl/pdvm_pkg.sv @@
// Shared types, constants and helpers for the perspective divide / viewport map.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package pdvm_pkg;

  localparam int DIV_STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES          = 8;   // 32 quotient bits after the fixed first step

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_ON  = 3'd4;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;
  localparam logic signed [33:0] Q_ONE   = 34'sh10000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] s;
    logic signed [31:0] t;
    logic signed [31:0] r;
    logic signed [31:0] q;
  } side_t;

  typedef struct packed {
    logic        valid;
    logic        neg;
    logic        wz;
    logic        one;
    logic [31:0] d;
    logic [31:0] rem;
    logic [31:0] quo;
    side_t       side;
  } div_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'(S32_MAX))      res = S32_MAX;
    else if (v < 64'(S32_MIN)) res = S32_MIN;
    else                       res = v[31:0];
    return res;
  endfunction

endpackage

@@ rtl/pdvm_div_stage.sv @@
// One registered stage of the restoring reciprocal divider: DIV_STEPS_PER_STAGE quotient bits.
// Depends on pdvm_pkg (div_t, DIV_STEPS_PER_STAGE).
module pdvm_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  pdvm_pkg::div_t st_i,
  output pdvm_pkg::div_t st_o
);

  pdvm_pkg::div_t st_r, st_nxt;

  always_comb begin
    logic [32:0] rem2;
    st_nxt = st_i;
    for (int k = 0; k < pdvm_pkg::DIV_STEPS_PER_STAGE; k++) begin
      rem2 = {st_nxt.rem, 1'b0};
      if (rem2 >= {1'b0, st_nxt.d}) begin
        rem2       = rem2 - {1'b0, st_nxt.d};
        st_nxt.quo = {st_nxt.quo[30:0], 1'b1};
      end else begin
        st_nxt.quo = {st_nxt.quo[30:0], 1'b0};
      end
      st_nxt.rem = rem2[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

@@ rtl/pdvm_recip.sv @@
// Pipelined reciprocal of clip w in Q16.16 (2^32 / w, saturated), carrying the vertex along.
// Depends on pdvm_pkg and pdvm_div_stage. Registers: setup, the DIV_STAGES divider stages, saturation.
module pdvm_recip (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [31:0]  clip_w,
  input  pdvm_pkg::side_t     side_i,
  output logic                valid_o,
  output logic signed [31:0]  inv_o,
  output logic                wz_o,
  output pdvm_pkg::side_t     side_o
);

  pdvm_pkg::div_t chain [pdvm_pkg::DIV_STAGES+1];
  pdvm_pkg::div_t setup_nxt;

  // First quotient step is fixed for |w| >= 2: remainder 1, quotient bit 0.
  always_comb begin
    setup_nxt.valid = in_valid;
    setup_nxt.neg   = clip_w[31];
    setup_nxt.d     = clip_w[31] ? 32'(-clip_w) : clip_w;
    setup_nxt.wz    = (clip_w == 32'sd0);
    setup_nxt.one   = (setup_nxt.d == 32'd1);
    setup_nxt.rem   = 32'd1;
    setup_nxt.quo   = 32'd0;
    setup_nxt.side  = side_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain[0].valid <= 1'b0;
    end else if (en) begin
      chain[0] <= setup_nxt;
    end
  end

  for (genvar g = 0; g < pdvm_pkg::DIV_STAGES; g++) begin : g_div
    pdvm_div_stage u_stage (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .st_i (chain[g]),
      .st_o (chain[g+1])
    );
  end

  logic               valid_r;
  logic signed [31:0] inv_r, inv_nxt;
  logic               wz_r;
  pdvm_pkg::side_t    side_r;

  always_comb begin
    pdvm_pkg::div_t f;
    f = chain[pdvm_pkg::DIV_STAGES];
    if (f.neg) begin
      inv_nxt = f.one ? pdvm_pkg::S32_MIN : -$signed(f.quo);
    end else if (f.wz || f.one || f.quo[31]) begin
      inv_nxt = pdvm_pkg::S32_MAX;
    end else begin
      inv_nxt = $signed(f.quo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= chain[pdvm_pkg::DIV_STAGES].valid;
      inv_r   <= inv_nxt;
      wz_r    <= chain[pdvm_pkg::DIV_STAGES].wz;
      side_r  <= chain[pdvm_pkg::DIV_STAGES].side;
    end
  end

  assign valid_o = valid_r;
  assign inv_o   = inv_r;
  assign wz_o    = wz_r;
  assign side_o  = side_r;

endmodule

@@ rtl/pdvm_qmul.sv @@
// Q16.16 multiply: exact product, floor by 2^16, saturate. Two register stages.
// Depends on pdvm_pkg (sat32).
module pdvm_qmul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] res
);

  logic signed [63:0] prod_r;
  logic signed [31:0] res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 64'(a) * 64'(b);
      res_r  <= pdvm_pkg::sat32(prod_r >>> 16);
    end
  end

  assign res = res_r;

endmodule

@@ rtl/perspective_divide_viewport_map.sv @@
// Perspective divide and viewport transform for a stream of clip-space vertices.
// Depends on pdvm_pkg, pdvm_recip, pdvm_div_stage and pdvm_qmul.
//
// Usage:
//   Input channel (in_*): one vertex request, x/y/z/w and s/t/r/q, all signed Q16.16.
//   A request is taken on a rising edge with in_valid high and in_stall low.
//   Output channel (out_*): window x/y, depth as (z/w + 1) / 2, 1/w, texture coordinates
//   (scaled by 1/w when texturing is on) and the w_zero flag, with out_valid/out_stall.
//   Config channel (cfg_*): write cfg_data to register cfg_index while idle;
//   cfg_ready is always high, unknown indexes are dropped.
//
// Throughput: one vertex per cycle while out_stall does not hold the pipeline. From
// accept to out_valid a vertex passes the reciprocal divider (4 quotient bits per stage
// over 8 stages, plus setup and saturation), two stages of Q16.16 multiply, one
// viewport multiply and the output register.
// Reset (synchronous, rst_n low) clears every valid bit and all config registers.
// When the receiver stalls a pending result, the whole pipeline holds in place and
// in_stall rises in the same cycle; nothing is dropped or repeated.
module perspective_divide_viewport_map (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [31:0]                  in_clip_x,
  input  logic signed [31:0]                  in_clip_y,
  input  logic signed [31:0]                  in_clip_z,
  input  logic signed [31:0]                  in_clip_w,
  input  logic signed [31:0]                  in_tex_s,
  input  logic signed [31:0]                  in_tex_t,
  input  logic signed [31:0]                  in_tex_r,
  input  logic signed [31:0]                  in_tex_q,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [31:0]                  out_win_x,
  output logic signed [31:0]                  out_win_y,
  output logic signed [31:0]                  out_win_depth,
  output logic signed [31:0]                  out_inv_w,
  output logic signed [31:0]                  out_s,
  output logic signed [31:0]                  out_t,
  output logic signed [31:0]                  out_r,
  output logic signed [31:0]                  out_q,
  output logic                                out_w_zero,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pdvm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pdvm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // ---------------- configuration registers ----------------
  logic signed [15:0] left_r, bottom_r;
  logic [14:0]        span_x_r, span_y_r;
  logic               tex_on_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      bottom_r <= '0;
      span_x_r <= '0;
      span_y_r <= '0;
      tex_on_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pdvm_pkg::REG_LEFT:   left_r   <= cfg_data;
        pdvm_pkg::REG_BOTTOM: bottom_r <= cfg_data;
        pdvm_pkg::REG_SPAN_X: span_x_r <= cfg_data[14:0];
        pdvm_pkg::REG_SPAN_Y: span_y_r <= cfg_data[14:0];
        pdvm_pkg::REG_TEX_ON: tex_on_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- global advance ----------------
  // Advance every stage unless a finished result is waiting on a stalled receiver.
  logic en;
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // ---------------- reciprocal of w ----------------
  pdvm_pkg::side_t    side_in, side_rc;
  logic               rc_valid, rc_wz;
  logic signed [31:0] rc_inv;

  assign side_in = '{x: in_clip_x, y: in_clip_y, z: in_clip_z,
                     s: in_tex_s, t: in_tex_t, r: in_tex_r, q: in_tex_q};

  pdvm_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_valid),
    .clip_w  (in_clip_w),
    .side_i  (side_in),
    .valid_o (rc_valid),
    .inv_o   (rc_inv),
    .wz_o    (rc_wz),
    .side_o  (side_rc)
  );

  // ---------------- Q16.16 products by 1/w ----------------
  logic signed [31:0] nx, ny, nz, ps, pt, pr, pq;

  pdvm_qmul u_mx (.clk(clk), .en(en), .a(side_rc.x), .b(rc_inv), .res(nx));
  pdvm_qmul u_my (.clk(clk), .en(en), .a(side_rc.y), .b(rc_inv), .res(ny));
  pdvm_qmul u_mz (.clk(clk), .en(en), .a(side_rc.z), .b(rc_inv), .res(nz));
  pdvm_qmul u_ms (.clk(clk), .en(en), .a(side_rc.s), .b(rc_inv), .res(ps));
  pdvm_qmul u_mt (.clk(clk), .en(en), .a(side_rc.t), .b(rc_inv), .res(pt));
  pdvm_qmul u_mr (.clk(clk), .en(en), .a(side_rc.r), .b(rc_inv), .res(pr));
  pdvm_qmul u_mq (.clk(clk), .en(en), .a(side_rc.q), .b(rc_inv), .res(pq));

  // Carry valid, 1/w, flag and raw texture coordinates beside the multipliers.
  logic               m1_valid_r, m2_valid_r;
  logic signed [31:0] m1_inv_r, m2_inv_r;
  logic               m1_wz_r, m2_wz_r;
  pdvm_pkg::side_t    m1_side_r, m2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
      m2_valid_r <= 1'b0;
    end else if (en) begin
      m1_valid_r <= rc_valid;
      m2_valid_r <= m1_valid_r;
      m1_inv_r   <= rc_inv;
      m2_inv_r   <= m1_inv_r;
      m1_wz_r    <= rc_wz;
      m2_wz_r    <= m1_wz_r;
      m1_side_r  <= side_rc;
      m2_side_r  <= m1_side_r;
    end
  end

  // ---------------- viewport multiply, depth, texture select ----------------
  logic               v_valid_r;
  logic signed [49:0] px_r, py_r;
  logic signed [31:0] depth_r, vs_r, vt_r, vr_r, vq_r, v_inv_r;
  logic               v_wz_r;
  logic signed [33:0] nx1, ny1, nz1;

  assign nx1 = 34'(nx) + pdvm_pkg::Q_ONE;
  assign ny1 = 34'(ny) + pdvm_pkg::Q_ONE;
  assign nz1 = 34'(nz) + pdvm_pkg::Q_ONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_valid_r <= 1'b0;
    end else if (en) begin
      v_valid_r <= m2_valid_r;
      px_r      <= 50'($signed({1'b0, span_x_r})) * 50'(nx1);
      py_r      <= 50'($signed({1'b0, span_y_r})) * 50'(ny1);
      depth_r   <= pdvm_pkg::sat32(64'(nz1 >>> 1));
      vs_r      <= tex_on_r ? ps : m2_side_r.s;
      vt_r      <= tex_on_r ? pt : m2_side_r.t;
      vr_r      <= tex_on_r ? pr : m2_side_r.r;
      vq_r      <= tex_on_r ? pq : m2_side_r.q;
      v_inv_r   <= m2_inv_r;
      v_wz_r    <= m2_wz_r;
    end
  end

  // ---------------- output register ----------------
  logic signed [63:0] wx_sum, wy_sum;
  assign wx_sum = (64'(left_r) <<< 16) + 64'(px_r >>> 1);
  assign wy_sum = (64'(bottom_r) <<< 16) + 64'(py_r >>> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r   <= v_valid_r;
      out_win_x     <= pdvm_pkg::sat32(wx_sum);
      out_win_y     <= pdvm_pkg::sat32(wy_sum);
      out_win_depth <= depth_r;
      out_inv_w     <= v_inv_r;
      out_s         <= vs_r;
      out_t         <= vt_r;
      out_r         <= vr_r;
      out_q         <= vq_r;
      out_w_zero    <= v_wz_r;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------- assertions ----------------
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input not held while result is stalled");

  a_wz_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_w_zero) |-> (out_inv_w == pdvm_pkg::S32_MAX))
    else $error("zero w without saturated reciprocal");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
